FILE: hdl/tcfc_pkg.sv
// ----------------------------------------------------------------------------
// Timecode frame converter package
// Shared types and codes of the timecode / frame count converter.
// ----------------------------------------------------------------------------
package tcfc_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_RATE  = 2'd2,
    ST_SKIP  = 2'd3
  } status_e;

  localparam logic [1:0] CFG_RATE = 2'd0;
  localparam logic [1:0] CFG_DROP = 2'd1;
  localparam logic [1:0] CFG_WRAP = 2'd2;

  typedef struct packed {
    logic [6:0]  rate;
    logic        drop;
    logic        bad;
    logic        wrap;
    logic [2:0]  d;
    logic [23:0] day;
    logic [15:0] per_ten;
    logic [12:0] min_div;
    logic [18:0] hour_div;
    logic [12:0] min60;
  } cfg_t;

  typedef struct packed {
    logic        op;
    status_e     status;
    logic        skip;
    logic [31:0] rem;
    logic [23:0] n;
    logic [7:0]  tens;
    logic [3:0]  mins;
    logic [4:0]  hh;
    logic [5:0]  mm;
    logic [5:0]  ss;
  } item_t;

endpackage

FILE: hdl/tcfc_front.sv
// ----------------------------------------------------------------------------
// Timecode frame converter front end
// Captures an item, forms the timecode sum for the reverse conversion and
// hands a common dividend to the division pipeline.
// ----------------------------------------------------------------------------
module tcfc_front #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcfc_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                op_i,
  input  logic [31:0]         count_in_i,
  input  logic [4:0]          hours_in_i,
  input  logic [5:0]          minutes_in_i,
  input  logic [5:0]          seconds_in_i,
  input  logic [6:0]          frames_in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tcfc_pkg::item_t     out_item_o
);

  localparam logic [31:0] CountMask = (COUNT_WIDTH >= 32) ? 32'hFFFF_FFFF :
                                      32'((64'd1 << COUNT_WIDTH) - 64'd1);

  logic [3:0] v_q;
  logic [4:0] adv;

  logic        a_op_q, b_op_q, c_op_q;
  logic [31:0] a_cnt_q, b_cnt_q, c_cnt_q;
  logic [4:0]  a_hh_q;
  logic [5:0]  a_mm_q, a_ss_q;
  logic [6:0]  a_ff_q, b_ff_q;
  logic [16:0] b_t_q, b_t_d;
  logic [10:0] b_tm_q, b_tm_d;
  logic        b_skip_q, b_skip_d, c_skip_q;
  logic [23:0] c_p_q, c_p_d;
  logic [12:0] c_dsub_q, c_dsub_d;
  logic [23:0] tm10_prod;
  logic [10:0] tm10;
  logic [3:0]  mm10;
  tcfc_pkg::item_t d_q, d_d;

  assign adv[4] = !out_stall_i;
  for (genvar g = 0; g < 4; g++) begin : g_adv
    assign adv[g] = !v_q[g] || adv[g+1];
  end
  assign in_stall_o  = !adv[0];
  assign out_valid_o = v_q[3];
  assign out_item_o  = d_q;

  always_comb begin
    b_tm_d   = 11'(a_hh_q) * 11'd60 + 11'(a_mm_q);
    b_t_d    = 17'(a_ss_q) + 17'(a_mm_q) * 17'd60 + 17'(a_hh_q) * 17'd3600;
    mm10     = 4'((11'(a_mm_q) * 11'd26) >> 8);
    b_skip_d = cfg_i.drop && a_op_q && (a_ff_q < 7'(cfg_i.d)) && (a_ss_q == 6'd0) &&
               (a_mm_q != 6'(mm10) * 6'd10);
  end

  always_comb begin
    tm10_prod = 24'(b_tm_q) * 24'd6554;
    tm10      = 11'(tm10_prod >> 16);
    c_p_d     = 24'(cfg_i.rate) * 24'(b_t_q) + 24'(b_ff_q);
    c_dsub_d  = 13'(cfg_i.d) * 13'(b_tm_q - tm10);
  end

  always_comb begin
    d_d        = '0;
    d_d.op     = c_op_q;
    d_d.skip   = c_skip_q;
    d_d.status = cfg_i.bad ? tcfc_pkg::ST_RATE : tcfc_pkg::ST_OK;
    d_d.rem    = c_op_q ? 32'(c_p_q - 24'(c_dsub_q)) : c_cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int i = 1; i < 4; i++) begin
        if (adv[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      a_op_q  <= op_i;
      a_cnt_q <= count_in_i & CountMask;
      a_hh_q  <= hours_in_i;
      a_mm_q  <= minutes_in_i;
      a_ss_q  <= seconds_in_i;
      a_ff_q  <= frames_in_i;
    end
    if (adv[1]) begin
      b_op_q   <= a_op_q;
      b_cnt_q  <= a_cnt_q;
      b_ff_q   <= a_ff_q;
      b_t_q    <= b_t_d;
      b_tm_q   <= b_tm_d;
      b_skip_q <= b_skip_d;
    end
    if (adv[2]) begin
      c_op_q   <= b_op_q;
      c_cnt_q  <= b_cnt_q;
      c_skip_q <= b_skip_q;
      c_p_q    <= c_p_d;
      c_dsub_q <= c_dsub_d;
    end
    if (adv[3]) begin
      d_q <= d_d;
    end
  end

endmodule

FILE: hdl/tcfc_divpipe.sv
// ----------------------------------------------------------------------------
// Timecode frame converter division pipeline
// One quotient bit per divide stage, plus latch, prep and adjust steps:
// day wrap, drop-frame correction, hours, minutes, seconds, frame remainder.
// ----------------------------------------------------------------------------
module tcfc_divpipe #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tcfc_pkg::cfg_t  cfg_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  tcfc_pkg::item_t in_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output tcfc_pkg::item_t out_item_o
);

  localparam int NumBits = (COUNT_WIDTH < 32) ? COUNT_WIDTH : 32;
  localparam int NQ      = NumBits - 16;
  localparam int PLatch  = NQ;
  localparam int PTens   = PLatch + 1;
  localparam int PMprep  = PTens + 8;
  localparam int PMins   = PMprep + 1;
  localparam int PAdj    = PMins + 4;
  localparam int PHh     = PAdj + 1;
  localparam int PMm     = PHh + 5;
  localparam int PSs     = PMm + 6;
  localparam int NS      = PSs + 6;

  function automatic logic [32:0] cs_f(logic [31:0] r, logic [23:0] dv, int k);
    logic [39:0] s;
    s = 40'(dv) << k;
    if (40'(r) >= s) return {1'b1, 32'(40'(r) - s)};
    return {1'b0, r};
  endfunction

  function automatic tcfc_pkg::item_t step_f(tcfc_pkg::item_t it, tcfc_pkg::cfg_t c,
                                             int idx);
    tcfc_pkg::item_t o;
    logic [32:0]     r;
    logic            drop0;
    logic [12:0]     adj;
    o     = it;
    r     = '0;
    drop0 = c.drop && !it.op;
    adj   = (13'(it.tens) * 13'd9 + 13'(it.mins)) * 13'(c.d);
    if (idx < PLatch) begin
      if (c.wrap) begin
        r     = cs_f(it.rem, c.day, NQ - 1 - idx);
        o.rem = r[31:0];
      end else if (idx == 0 && it.rem >= 32'(c.day) && it.status == tcfc_pkg::ST_OK) begin
        o.status = tcfc_pkg::ST_RANGE;
      end
    end else if (idx == PLatch) begin
      o.n    = it.rem[23:0];
      o.rem  = 32'(it.rem[23:0]);
      o.tens = '0;
      o.mins = '0;
      o.hh   = '0;
      o.mm   = '0;
      o.ss   = '0;
    end else if (idx < PMprep) begin
      if (drop0) begin
        r      = cs_f(it.rem, 24'(c.per_ten), PMprep - 1 - idx);
        o.rem  = r[31:0];
        o.tens = {it.tens[6:0], r[32]};
      end
    end else if (idx == PMprep) begin
      if (drop0) o.rem = (it.rem < 32'(c.d)) ? '0 : it.rem - 32'(c.d);
    end else if (idx < PAdj) begin
      if (drop0) begin
        r      = cs_f(it.rem, 24'(c.min_div), PAdj - 1 - idx);
        o.rem  = r[31:0];
        o.mins = {it.mins[2:0], r[32]};
      end
    end else if (idx == PAdj) begin
      if (drop0) o.n = it.n + 24'(adj);
      o.rem = drop0 ? 32'(it.n + 24'(adj)) : 32'(it.n);
    end else if (idx < PMm) begin
      if (!it.op) begin
        r     = cs_f(it.rem, 24'(c.hour_div), PMm - 1 - idx);
        o.rem = r[31:0];
        o.hh  = {it.hh[3:0], r[32]};
      end
    end else if (idx < PSs) begin
      if (!it.op) begin
        r     = cs_f(it.rem, 24'(c.min60), PSs - 1 - idx);
        o.rem = r[31:0];
        o.mm  = {it.mm[4:0], r[32]};
      end
    end else begin
      if (!it.op) begin
        r     = cs_f(it.rem, 24'(c.rate), NS - 1 - idx);
        o.rem = r[31:0];
        o.ss  = {it.ss[4:0], r[32]};
      end
    end
    return o;
  endfunction

  tcfc_pkg::item_t st_q [NS];
  tcfc_pkg::item_t st_d [NS];
  logic [NS-1:0]   v_q;
  logic [NS:0]     adv;

  assign adv[NS]     = !out_stall_i;
  assign in_stall_o  = !adv[0];
  assign out_valid_o = v_q[NS-1];
  assign out_item_o  = st_q[NS-1];

  for (genvar g = 0; g < NS; g++) begin : g_stage
    assign adv[g] = !v_q[g] || adv[g+1];
    if (g == 0) begin : g_first
      always_comb st_d[g] = step_f(in_item_i, cfg_i, g);
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[g] <= 1'b0;
        end else if (adv[g]) begin
          v_q[g] <= in_valid_i;
        end
      end
    end else begin : g_rest
      always_comb st_d[g] = step_f(st_q[g-1], cfg_i, g);
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[g] <= 1'b0;
        end else if (adv[g]) begin
          v_q[g] <= v_q[g-1];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv[g]) st_q[g] <= st_d[g];
    end
  end

endmodule

FILE: hdl/smpte_timecode_frame_converter.sv
// ----------------------------------------------------------------------------
// SMPTE timecode frame converter
// Converts frame counts to timecode and back, with drop-frame numbering.
// It has four front stages, min(COUNT_WIDTH, 32) + 16 division stages and one
// output stage. Throughput is one transfer per cycle; a stage that holds an item
// keeps it in place on stall.
// Reset clears all valid bits and loads rate 25, drop mode off, day wrap on.
// ----------------------------------------------------------------------------
module smpte_timecode_frame_converter #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [31:0] count_in_i,
  input  logic [4:0]  hours_in_i,
  input  logic [5:0]  minutes_in_i,
  input  logic [5:0]  seconds_in_i,
  input  logic [6:0]  frames_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] count_out_o,
  output logic [4:0]  hours_out_o,
  output logic [5:0]  minutes_out_o,
  output logic [5:0]  seconds_out_o,
  output logic [6:0]  frames_out_o,
  output logic        drop_flag_o,
  output logic [1:0]  status_o
);

  logic [6:0]      rate_q;
  logic            drop_q, wrap_q;
  logic [6:0]      rate_eff;
  logic [2:0]      d_val;
  tcfc_pkg::cfg_t  cfg_q, cfg_d;

  logic            f_valid, f_stall, p_valid, p_stall;
  tcfc_pkg::item_t f_item, p_item;
  logic            out_en;

  logic [23:0] count_d;
  logic [4:0]  hh_d;
  logic [5:0]  mm_d, ss_d;
  logic [6:0]  ff_d;
  logic        drop_flag_d;
  logic [1:0]  status_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= 7'd25;
      drop_q <= 1'b0;
      wrap_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tcfc_pkg::CFG_RATE: rate_q <= cfg_data_i;
        tcfc_pkg::CFG_DROP: drop_q <= cfg_data_i[0];
        tcfc_pkg::CFG_WRAP: wrap_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rate_eff = (rate_q == 7'd0) ? 7'd1 : rate_q;
    d_val    = !drop_q ? 3'd0 : (rate_eff == 7'd30) ? 3'd2 : (rate_eff == 7'd60) ? 3'd4 : 3'd0;
    cfg_d.rate     = rate_eff;
    cfg_d.drop     = drop_q;
    cfg_d.bad      = drop_q && (rate_eff != 7'd30) && (rate_eff != 7'd60);
    cfg_d.wrap     = wrap_q;
    cfg_d.d        = d_val;
    cfg_d.day      = 24'(rate_eff) * 24'd86400 - 24'(d_val) * 24'd1296;
    cfg_d.per_ten  = 16'(rate_eff) * 16'd600 - 16'(d_val) * 16'd9;
    cfg_d.min_div  = 13'(rate_eff) * 13'd60 - 13'(d_val);
    cfg_d.hour_div = 19'(rate_eff) * 19'd3600;
    cfg_d.min60    = 13'(rate_eff) * 13'd60;
  end

  always_ff @(posedge clk_i) begin
    cfg_q <= cfg_d;
  end

  tcfc_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .op_i         (op_i),
    .count_in_i   (count_in_i),
    .hours_in_i   (hours_in_i),
    .minutes_in_i (minutes_in_i),
    .seconds_in_i (seconds_in_i),
    .frames_in_i  (frames_in_i),
    .out_valid_o  (f_valid),
    .out_stall_i  (f_stall),
    .out_item_o   (f_item)
  );

  tcfc_divpipe #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_divpipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (f_valid),
    .in_stall_o  (f_stall),
    .in_item_i   (f_item),
    .out_valid_o (p_valid),
    .out_stall_i (p_stall),
    .out_item_o  (p_item)
  );

  assign out_en  = !(out_valid_o && out_stall_i);
  assign p_stall = !out_en;

  always_comb begin
    count_d     = '0;
    hh_d        = '0;
    mm_d        = '0;
    ss_d        = '0;
    ff_d        = '0;
    drop_flag_d = 1'b0;
    status_d    = p_item.status;
    if (p_item.status == tcfc_pkg::ST_OK) begin
      if (p_item.op) begin
        count_d  = p_item.n;
        status_d = p_item.skip ? tcfc_pkg::ST_SKIP : tcfc_pkg::ST_OK;
      end else begin
        hh_d        = p_item.hh;
        mm_d        = p_item.mm;
        ss_d        = p_item.ss;
        ff_d        = p_item.rem[6:0];
        drop_flag_d = cfg_q.drop;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_en) begin
      out_valid_o <= p_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      count_out_o   <= count_d;
      hours_out_o   <= hh_d;
      minutes_out_o <= mm_d;
      seconds_out_o <= ss_d;
      frames_out_o  <= ff_d;
      drop_flag_o   <= drop_flag_d;
      status_o      <= status_d;
    end
  end

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == tcfc_pkg::ST_RANGE || status_o == tcfc_pkg::ST_RATE)
    |-> count_out_o == 24'd0 && hours_out_o == 5'd0 && frames_out_o == 7'd0)
    else $error("Error result carries nonzero fields.");

  a_drop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drop_flag_o |-> status_o == tcfc_pkg::ST_OK && count_out_o == 24'd0)
    else $error("Drop flag set on a result that is not a good timecode.");

  a_hours: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hours_out_o < 5'd24 && minutes_out_o < 6'd60 && seconds_out_o < 6'd60)
    else $error("Timecode field out of range.");

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Timecode frame converter testbench
// Drives frame count and timecode conversions through the converter under
// several rate, drop-frame and day-wrap settings, with random idle and stall
// patterns, and checks every result against a behavioral predictor.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 53;

  typedef struct {
    logic [23:0] count;
    logic [4:0]  hh;
    logic [5:0]  mm;
    logic [5:0]  ss;
    logic [6:0]  ff;
    logic        drop;
    tcfc_pkg::status_e status;
  } timecode_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [6:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i = 1'b0;
  logic [31:0] count_in_i = '0;
  logic [4:0]  hours_in_i = '0;
  logic [5:0]  minutes_in_i = '0;
  logic [5:0]  seconds_in_i = '0;
  logic [6:0]  frames_in_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [23:0] count_out_o;
  logic [4:0]  hours_out_o;
  logic [5:0]  minutes_out_o;
  logic [5:0]  seconds_out_o;
  logic [6:0]  frames_out_o;
  logic        drop_flag_o;
  logic [1:0]  status_o;

  smpte_timecode_frame_converter uut (.*);

  logic [6:0] rate_reg = 7'd25;
  logic       drop_reg = 1'b0;
  logic       wrap_reg = 1'b1;

  timecode_result_t expected_q[$];
  int  mismatches = 0;
  int  results_seen = 0;
  int  items_sent = 0;
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  hold_cycles = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic timecode_result_t convert(logic op, logic [31:0] cnt, logic [4:0] h,
                                               logic [5:0] m, logic [5:0] s, logic [6:0] f);
    timecode_result_t r;
    longint unsigned rt, d, day, n, per_ten, tens, rest, mins, tm, hh, mm, ss;
    r = '{count: '0, hh: '0, mm: '0, ss: '0, ff: '0, drop: 1'b0, status: tcfc_pkg::ST_OK};
    rt = (rate_reg == 0) ? 1 : rate_reg;
    d = 0;
    if (drop_reg) begin
      if (rt == 30) d = 2;
      else if (rt == 60) d = 4;
      else begin
        r.status = tcfc_pkg::ST_RATE;
        return r;
      end
    end
    day = 86400 * rt - 1296 * d;
    if (!op) begin
      n = cnt;
      if (n >= day) begin
        if (!wrap_reg) begin
          r.status = tcfc_pkg::ST_RANGE;
          return r;
        end
        n = n % day;
      end
      if (drop_reg) begin
        per_ten = 600 * rt - 9 * d;
        tens = n / per_ten;
        rest = n - tens * per_ten;
        mins = (rest < d) ? 0 : (rest - d) / (60 * rt - d);
        n += (tens * 9 + mins) * d;
      end
      hh = n / (3600 * rt);
      n -= hh * 3600 * rt;
      mm = n / (60 * rt);
      n -= mm * 60 * rt;
      ss = n / rt;
      n -= ss * rt;
      r.hh = hh[4:0];
      r.mm = mm[5:0];
      r.ss = ss[5:0];
      r.ff = n[6:0];
      r.drop = drop_reg;
      return r;
    end
    n = f + rt * (s + 60 * m + 3600 * h);
    if (drop_reg) begin
      tm = 60 * h + m;
      if (f < d && s == 0 && (m % 10) != 0) r.status = tcfc_pkg::ST_SKIP;
      n -= d * (tm - tm / 10);
    end
    if (n >= day) begin
      if (!wrap_reg) begin
        r.status = tcfc_pkg::ST_RANGE;
        return r;
      end
      n = n % day;
    end
    r.count = n[23:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("t=%0t %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    timecode_result_t e;
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, results so far", results_seen, 0);
      end else begin
        e = expected_q.pop_front();
        if (count_out_o !== e.count) report_mismatch("count", count_out_o, e.count);
        if (hours_out_o !== e.hh) report_mismatch("hours", hours_out_o, e.hh);
        if (minutes_out_o !== e.mm) report_mismatch("minutes", minutes_out_o, e.mm);
        if (seconds_out_o !== e.ss) report_mismatch("seconds", seconds_out_o, e.ss);
        if (frames_out_o !== e.ff) report_mismatch("frames", frames_out_o, e.ff);
        if (drop_flag_o !== e.drop) report_mismatch("drop flag", drop_flag_o, e.drop);
        if (status_o !== e.status) report_mismatch("status", status_o, e.status);
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_item(logic op, logic [31:0] cnt, logic [4:0] h, logic [5:0] m,
                           logic [5:0] s, logic [6:0] f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    count_in_i <= cnt;
    hours_in_i <= h;
    minutes_in_i <= m;
    seconds_in_i <= s;
    frames_in_i <= f;
    expected_q.push_back(convert(op, cnt, h, m, s, f));
    items_sent++;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tcfc_pkg::CFG_RATE: rate_reg = val;
      tcfc_pkg::CFG_DROP: drop_reg = val[0];
      tcfc_pkg::CFG_WRAP: wrap_reg = val[0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [6:0] rt, logic dr, logic wr);
    write_reg(tcfc_pkg::CFG_RATE, rt);
    write_reg(tcfc_pkg::CFG_DROP, 7'(dr));
    write_reg(tcfc_pkg::CFG_WRAP, 7'(wr));
  endtask

  task automatic send_random(int count);
    longint unsigned rt, day;
    logic [31:0] c;
    repeat (count) begin
      rt = (rate_reg == 0) ? 1 : rate_reg;
      day = 86400 * rt;
      if ($urandom_range(1)) begin
        if ($urandom_range(9) < 8)
          send_item(1'b1, '0, 5'($urandom_range(23)), 6'($urandom_range(59)),
                    6'($urandom_range(59)), 7'($urandom_range(32'(rt - 1))));
        else
          send_item(1'b1, '0, 5'($urandom), 6'($urandom), 6'($urandom), 7'($urandom));
      end else begin
        case ($urandom_range(3))
          0: c = $urandom;
          1: c = $urandom_range(20);
          default: c = $urandom_range(32'(day + 1000));
        endcase
        send_item(1'b0, c, '0, '0, '0, '0);
      end
    end
  endtask

  task automatic test_directed();
    configure(7'd30, 1'b1, 1'b1);
    send_item(1'b0, 32'd0, 0, 0, 0, 0);
    send_item(1'b0, 32'd1799, 0, 0, 0, 0);
    send_item(1'b0, 32'd1800, 0, 0, 0, 0);
    send_item(1'b0, 32'd17982, 0, 0, 0, 0);
    send_item(1'b0, 32'd2589407, 0, 0, 0, 0);
    send_item(1'b0, 32'hFFFF_FFFF, 0, 0, 0, 0);
    send_item(1'b1, '0, 0, 1, 0, 0);
    send_item(1'b1, '0, 0, 1, 0, 2);
    send_item(1'b1, '0, 0, 10, 0, 0);
    send_item(1'b1, '0, 0, 40, 0, 0);
    send_item(1'b1, '0, 23, 59, 59, 29);
    send_item(1'b1, '0, 31, 63, 63, 127);
    drain();
    configure(7'd30, 1'b1, 1'b0);
    send_item(1'b0, 32'd2589408, 0, 0, 0, 0);
    send_item(1'b1, '0, 24, 0, 0, 0);
    send_item(1'b0, 32'd2589407, 0, 0, 0, 0);
    drain();
    configure(7'd25, 1'b1, 1'b1);
    send_item(1'b0, 32'd5, 0, 0, 0, 0);
    send_item(1'b1, '0, 1, 2, 3, 4);
    drain();
    configure(7'd0, 1'b0, 1'b0);
    send_item(1'b0, 32'd86399, 0, 0, 0, 0);
    send_item(1'b0, 32'd86400, 0, 0, 0, 0);
    drain();
    configure(7'd127, 1'b0, 1'b1);
    send_item(1'b0, 32'hFFFF_FFFF, 0, 0, 0, 0);
    send_item(1'b1, '0, 31, 63, 63, 127);
    drain();
  endtask

  task automatic test_random_settings();
    logic [6:0] rates[6] = '{7'd30, 7'd60, 7'd24, 7'd1, 7'd120, 7'd60};
    logic       drops[6] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};
    int idle[4] = '{0, 76, 0, 20};
    int stl[4] = '{0, 0, 76, 20};
    for (int i = 0; i < 6; i++) begin
      configure(rates[i], drops[i], 1'($urandom_range(1)));
      for (int p = 0; p < 4; p++) begin
        send_idle_pct = idle[p];
        stall_pct = stl[p];
        send_random(45);
      end
      send_idle_pct = 0;
      stall_pct = 0;
      drain();
    end
  endtask

  task automatic test_backpressure();
    configure(7'd60, 1'b1, 1'b1);
    hold_cycles = 300;
    send_random(150);
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_settings();
    test_backpressure();
    $display("Covered %0d conversions over both directions, drop and non-drop rates,",
             items_sent);
    $display("day wrap and range flagging, idle, stall and long back-pressure phases.");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("smpte_timecode_frame_converter: match");
    end else begin
      $display("smpte_timecode_frame_converter: mismatch");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("smpte_timecode_frame_converter: mismatch");
    $finish;
  end

endmodule
